@@ hw/rtl/tll_pkg.sv @@
`timescale 1ns / 1ps
// tll_pkg: shared types, codes and the character classifier of the token lexer
// no dependencies; imported by every module of the lexer

package tll_pkg;

    // sizes
    localparam int NEST_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 4;
    localparam int CNT_W           = 3;
    localparam int IDX_W           = 2;

    // token kinds
    localparam logic [2:0] K_FEF   = 3'd0;
    localparam logic [2:0] K_INNER = 3'd1;
    localparam logic [2:0] K_TEXT  = 3'd2;
    localparam logic [2:0] K_GEN   = 3'd3;
    localparam logic [2:0] K_CHAR  = 3'd4;
    localparam logic [2:0] K_END   = 3'd5;
    localparam logic [2:0] K_COM   = 3'd6;
    localparam logic [2:0] K_COMNE = 3'd7;

    // character classes
    localparam logic [2:0] CLS_IGN = 3'd0;
    localparam logic [2:0] CLS_FEF = 3'd1;
    localparam logic [2:0] CLS_ALF = 3'd2;
    localparam logic [2:0] CLS_NUM = 3'd3;
    localparam logic [2:0] CLS_SEP = 3'd4;
    localparam logic [2:0] CLS_CHA = 3'd5;

    // special characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // configuration register index
    localparam logic REG_START_IN_COMMENT = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       token_first;
        logic       token_done;
        logic       last_of_item;
    } t_out_item;

    // one result without its per-item flag
    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       token_first;
        logic       token_done;
    } t_res;

    // all results caused by one item
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [CNT_W-1:0]   count;
    } t_group;

    function automatic t_res make_res(input logic [2:0] kind, input logic [7:0] vbyte,
                                      input logic valid, input logic first,
                                      input logic done);
        t_res r;
        r.token_kind  = kind;
        r.value_byte  = valid ? vbyte : 8'h00;
        r.byte_valid  = valid;
        r.token_first = first;
        r.token_done  = done;
        return r;
    endfunction

    // 128-entry class map, bytes above DEL ignored
    function automatic logic [2:0] char_class(input logic [7:0] c);
        logic [2:0] cls;
        if (c > CH_DEL) begin
            cls = CLS_IGN;
        end else if ((c >= 8'h09 && c <= 8'h0D) || c == CH_CAN || c == CH_SPACE) begin
            cls = CLS_FEF;
        end else if (c < CH_SPACE) begin
            cls = CLS_IGN;
        end else if (c == 8'h2C || c == 8'h3A || c == 8'h3B || c == 8'h3C || c == CH_GT) begin
            cls = CLS_SEP;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_NUM;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            cls = CLS_ALF;
        end else begin
            cls = CLS_CHA;
        end
        return cls;
    endfunction

endpackage

@@ hw/rtl/tll_front.sv @@
`timescale 1ns / 1ps
// tll_front: classifies each accepted byte and runs the lexer state machine,
// producing the whole group of results of one item in the cycle it is accepted; uses tll_pkg

module tll_front
    import tll_pkg::*;
#(
    parameter int NEST_BITS = NEST_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_start_in_comment,
    output t_group   o_group,
    output logic     o_group_valid
);

    // lexer modes
    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_SLASH     = 4'd1;
    localparam logic [3:0] M_BSL       = 4'd2;
    localparam logic [3:0] M_FEF       = 4'd3;
    localparam logic [3:0] M_GEN       = 4'd4;
    localparam logic [3:0] M_TEXT      = 4'd5;
    localparam logic [3:0] M_TEXT_ESC  = 4'd6;
    localparam logic [3:0] M_TII       = 4'd7;
    localparam logic [3:0] M_TII_ESC   = 4'd8;
    localparam logic [3:0] M_INNER     = 4'd9;
    localparam logic [3:0] M_INNER_ESC = 4'd10;
    localparam logic [3:0] M_INNER_Q   = 4'd11;
    localparam logic [3:0] M_C_IN      = 4'd12;
    localparam logic [3:0] M_C_STAR    = 4'd13;
    localparam logic [3:0] M_C_SLASH   = 4'd14;
    localparam logic [3:0] M_C_NL      = 4'd15;

    localparam logic [NEST_BITS-1:0] DEPTH_ONE = NEST_BITS'(1);
    localparam logic [NEST_BITS-1:0] DEPTH_MAX = {NEST_BITS{1'b1}};

    logic [3:0]           r_mode, n_mode;
    logic [NEST_BITS-1:0] r_depth, n_depth;
    logic [7:0]           r_held, n_held;
    logic                 r_seen, n_seen;

    t_res [MAX_RES-1:0]   v_res;
    logic [CNT_W-1:0]     v_cnt;
    logic                 v_redo;
    logic                 v_take;
    logic                 v_slash_sp;
    logic                 v_ign;
    logic [7:0]           ch;
    logic [2:0]           cls;

    assign ch  = i_item.data_byte;
    assign cls = char_class(ch);

    // next-state and result group of the lexer
    always_comb begin
        n_mode     = r_mode;
        n_depth    = r_depth;
        n_held     = r_held;
        n_seen     = r_seen;
        v_res      = '0;
        v_cnt      = '0;
        v_redo     = 1'b0;
        v_take     = 1'b0;
        v_slash_sp = 1'b0;
        v_ign      = !i_item.end_of_message && (cls == CLS_IGN);

        // first token of a message may open as a comment
        if (!n_seen) begin
            n_seen = 1'b1;
            if (i_start_in_comment && n_mode == M_IDLE) begin
                v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, 8'h00, 1'b0, 1'b1, 1'b0);
                v_cnt   = v_cnt + CNT_W'(1);
                n_depth = DEPTH_ONE;
                n_held  = 8'h00;
                n_mode  = M_C_IN;
            end
        end

        if (i_item.end_of_message) begin
            // close the open token, then the end token
            case (n_mode)
                M_SLASH: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_CHAR, CH_SLASH, 1'b1, 1'b1, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_BSL: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_CHAR, CH_BSL, 1'b1, 1'b1, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_FEF: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_FEF, 8'h00, 1'b0, 1'b0, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_GEN: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_GEN, 8'h00, 1'b0, 1'b0, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_TEXT, M_TEXT_ESC, M_TII, M_TII_ESC: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_INNER, M_INNER_ESC, M_INNER_Q: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, 8'h00, 1'b0, 1'b0, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                M_C_IN, M_C_STAR, M_C_SLASH, M_C_NL: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, 8'h00, 1'b0, 1'b0, 1'b1);
                    v_cnt = v_cnt + CNT_W'(1);
                end
                default: begin
                end
            endcase
            v_res[v_cnt[IDX_W-1:0]] = make_res(K_END, 8'h00, 1'b0, 1'b1, 1'b1);
            v_cnt   = v_cnt + CNT_W'(1);
            n_mode  = M_IDLE;
            n_depth = '0;
            n_held  = 8'h00;
            n_seen  = 1'b0;
        end else begin
            // data byte in the current mode
            case (n_mode)
                M_SLASH: begin
                    if (ch == CH_STAR) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, 8'h00, 1'b0, 1'b1, 1'b0);
                        v_cnt   = v_cnt + CNT_W'(1);
                        n_depth = DEPTH_ONE;
                        n_held  = 8'h00;
                        n_mode  = M_C_IN;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_CHAR, CH_SLASH, 1'b1, 1'b1, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_redo = 1'b1;
                    end
                end
                M_BSL: begin
                    if (ch == CH_QUOTE) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, 8'h00, 1'b0, 1'b1, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_INNER;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_CHAR, CH_BSL, 1'b1, 1'b1, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_redo = 1'b1;
                    end
                end
                M_FEF: begin
                    if (cls == CLS_FEF) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_FEF, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_FEF, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_redo = 1'b1;
                    end
                end
                M_GEN: begin
                    if (cls == CLS_ALF || cls == CLS_NUM || cls == CLS_CHA) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_GEN, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_GEN, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_redo = 1'b1;
                    end
                end
                M_TEXT: begin
                    if (ch == CH_QUOTE) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else if (ch == CH_BSL) begin
                        n_mode = M_TEXT_ESC;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                    end
                end
                M_TEXT_ESC: begin
                    if (ch == CH_BSL) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, CH_BSL, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_TEXT;
                    end else if (ch == CH_QUOTE) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, CH_BSL, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, CH_QUOTE, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_TII;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, CH_SPACE, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_TEXT;
                    end
                end
                M_TII: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, ch, 1'b1, 1'b0, 1'b0);
                    v_cnt = v_cnt + CNT_W'(1);
                    if (ch == CH_BSL) begin
                        n_mode = M_TII_ESC;
                    end
                end
                M_TII_ESC: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, ch, 1'b1, 1'b0, 1'b0);
                    v_cnt = v_cnt + CNT_W'(1);
                    if (ch == CH_BSL) begin
                        n_mode = M_TII;
                    end else if (ch == CH_QUOTE) begin
                        n_mode = M_TEXT;
                    end else begin
                        // escaped ordinary byte shows twice
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_TII;
                    end
                end
                M_INNER: begin
                    if (ch == CH_BSL) begin
                        n_mode = M_INNER_ESC;
                    end else if (ch == CH_QUOTE) begin
                        n_mode = M_INNER_Q;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                    end
                end
                M_INNER_ESC: begin
                    if (ch == CH_BSL) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, CH_BSL, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_INNER;
                    end else if (ch == CH_QUOTE) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, CH_SPACE, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, ch, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_INNER;
                    end
                end
                M_INNER_Q: begin
                    // doubled quote gives one quote, a lone quote drops this byte
                    if (ch == CH_QUOTE) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_INNER, CH_QUOTE, 1'b1, 1'b0, 1'b0);
                        v_cnt = v_cnt + CNT_W'(1);
                    end
                    n_mode = M_INNER;
                end
                M_C_IN: begin
                    v_take     = 1'b1;
                    v_slash_sp = 1'b1;
                end
                M_C_STAR: begin
                    if (ch == CH_SLASH && n_depth != '0) begin
                        n_depth = n_depth - DEPTH_ONE;
                    end
                    if (ch == CH_SLASH && n_depth == '0) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, n_held, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_take = 1'b1;
                    end
                end
                M_C_SLASH: begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, n_held, 1'b1, 1'b0, 1'b0);
                    v_cnt = v_cnt + CNT_W'(1);
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, ch, 1'b1, 1'b0, 1'b0);
                    v_cnt = v_cnt + CNT_W'(1);
                    if (ch == CH_STAR) begin
                        // nested comment opens, depth saturates
                        if (n_depth != DEPTH_MAX) begin
                            n_depth = n_depth + DEPTH_ONE;
                        end
                        n_mode = M_C_IN;
                    end else if (ch == CH_SLASH) begin
                        n_mode = M_C_SLASH;
                    end else begin
                        n_mode = M_C_IN;
                    end
                end
                M_C_NL: begin
                    if (ch == CH_GT) begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_COMNE, 8'h00, 1'b0, 1'b0, 1'b1);
                        v_cnt  = v_cnt + CNT_W'(1);
                        n_mode = M_IDLE;
                    end else begin
                        v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, n_held, 1'b1, 1'b0, 1'b0);
                        v_cnt  = v_cnt + CNT_W'(1);
                        v_take = 1'b1;
                    end
                end
                default: begin
                    v_redo = 1'b1;
                end
            endcase

            // byte starts a fresh token
            if (v_redo) begin
                if (cls == CLS_FEF) begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_FEF, ch, 1'b1, 1'b1, 1'b0);
                    v_cnt  = v_cnt + CNT_W'(1);
                    n_mode = M_FEF;
                end else if (cls == CLS_SEP) begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_CHAR, ch, 1'b1, 1'b1, 1'b1);
                    v_cnt  = v_cnt + CNT_W'(1);
                    n_mode = M_IDLE;
                end else if (ch == CH_QUOTE) begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
                    v_cnt  = v_cnt + CNT_W'(1);
                    n_mode = M_TEXT;
                end else if (ch == CH_SLASH) begin
                    n_mode = M_SLASH;
                end else if (ch == CH_BSL) begin
                    n_mode = M_BSL;
                end else begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_GEN, ch, 1'b1, 1'b1, 1'b0);
                    v_cnt  = v_cnt + CNT_W'(1);
                    n_mode = M_GEN;
                end
            end

            // byte inside a comment body
            if (v_take) begin
                if (ch == CH_STAR) begin
                    n_held = ch;
                    n_mode = M_C_STAR;
                end else if (v_slash_sp && ch == CH_SLASH) begin
                    n_held = ch;
                    n_mode = M_C_SLASH;
                end else if (ch == CH_LF || ch == CH_FF) begin
                    n_held = ch;
                    n_mode = M_C_NL;
                end else begin
                    v_res[v_cnt[IDX_W-1:0]] = make_res(K_COM, ch, 1'b1, 1'b0, 1'b0);
                    v_cnt  = v_cnt + CNT_W'(1);
                    n_mode = M_C_IN;
                end
            end
        end
    end

    // lexer state, held across ignored bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_depth <= '0;
            r_held  <= 8'h00;
            r_seen  <= 1'b0;
        end else if (i_accept && !v_ign) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_held  <= n_held;
            r_seen  <= n_seen;
        end
    end

    assign o_group.res   = v_res;
    assign o_group.count = v_cnt;
    assign o_group_valid = i_accept && !v_ign && (v_cnt != '0);

endmodule

@@ hw/rtl/tll_queue.sv @@
`timescale 1ns / 1ps
// tll_queue: short queue of result groups between the lexer front and the output side
// uses t_group from tll_pkg

module tll_queue
    import tll_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_group i_wdata,
    input  logic   i_rd,
    output t_group o_rdata,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic               wr_en;
    logic               rd_en;

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_occ    = r_occ;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (rd_en && !wr_en) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_occ    <= n_occ;
        end
    end

    // group storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_occ == '0);
    assign o_full  = (r_occ == OCC_W'(DEPTH));

endmodule

@@ hw/rtl/tll_back.sv @@
`timescale 1ns / 1ps
// tll_back: walks the group at the queue head and presents its results one per transfer
// uses t_group and t_out_item from tll_pkg

module tll_back
    import tll_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group    i_head,
    input  logic      i_head_empty,
    input  logic      i_pop,
    output t_out_item o_result,
    output logic      o_empty,
    output logic      o_head_done
);

    logic [IDX_W-1:0] r_sub;
    logic             sub_last;
    logic             take;
    t_res             cur;

    assign cur      = i_head.res[r_sub];
    assign sub_last = ((CNT_W'(r_sub) + CNT_W'(1)) == i_head.count);
    assign take     = i_pop && !i_head_empty;

    // index of the result within the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (take) begin
            r_sub <= sub_last ? '0 : r_sub + IDX_W'(1);
        end
    end

    assign o_result.token_kind   = cur.token_kind;
    assign o_result.value_byte   = cur.value_byte;
    assign o_result.byte_valid   = cur.byte_valid;
    assign o_result.token_first  = cur.token_first;
    assign o_result.token_done   = cur.token_done;
    assign o_result.last_of_item = sub_last;
    assign o_empty               = i_head_empty;
    assign o_head_done           = take && sub_last;

endmodule

@@ hw/rtl/tl1_token_lexer.sv @@
`timescale 1ns / 1ps
// tl1_token_lexer: streaming lexer top level, front classifier, group queue and output side
// depends on tll_pkg, tll_front, tll_queue and tll_back
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  input     | push / full            | i_data   (t_in_item)
//  result    | empty / pop            | o_result (t_out_item)
//  config    | psel penable pwrite    | paddr pwdata prdata, pready tied high
//
// an item is lexed in the cycle it is accepted; its result group is registered in the group queue
// one item per cycle while the group queue has room; the output side gives one result
// per cycle while results wait and pop is high, so an item with k results takes k result transfers
// full rises when the group queue (QUEUE_DEPTH groups) is occupied; ignored bytes take no slot
// synchronous reset clears the lexer state, the queue and start_in_comment

module tl1_token_lexer
    import tll_pkg::*;
#(
    parameter int NEST_BITS   = NEST_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_data,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   r_start_in_comment;
    logic   cfg_wr;
    logic   in_accept;
    logic   q_full;
    logic   q_empty;
    logic   grp_valid;
    logic   head_done;
    t_group grp;
    t_group head;

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_in_comment <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_START_IN_COMMENT) begin
            r_start_in_comment <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_START_IN_COMMENT) ? {31'd0, r_start_in_comment} : 32'd0;
    assign pready = 1'b1;

    // input transfer
    assign in_accept = push && !q_full;
    assign full      = q_full;

    tll_front #(
        .NEST_BITS (NEST_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_item             (i_data),
        .i_start_in_comment (r_start_in_comment),
        .o_group            (grp),
        .o_group_valid      (grp_valid)
    );

    tll_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (grp_valid),
        .i_wdata (grp),
        .i_rd    (head_done),
        .o_rdata (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tll_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (q_empty),
        .i_pop        (pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .o_head_done  (head_done)
    );

endmodule

@@ hw/rtl/tll_checker.sv @@
`timescale 1ns / 1ps
// tll_checker: port-level checks of the token lexer, attached by bind
// uses tll_pkg; watches only the ports of tl1_token_lexer

module tll_checker
    import tll_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // results only follow an accepted input transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(empty) && !$past(push && !full)) |-> empty)
        else $error("result appeared without an input transfer");

    // value byte is zero when not carried
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.byte_valid) |-> (o_result.value_byte == 8'h00))
        else $error("value byte set without byte_valid");

    // end token is a whole token and closes its item
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.token_kind == K_END) |->
        (o_result.token_first && o_result.token_done && o_result.last_of_item))
        else $error("end token not first, done and last");

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind tl1_token_lexer tll_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

@@ dv/tb_tl1_token_lexer.sv @@
`timescale 1ns / 1ps
// tb_tl1_token_lexer: self-checking testbench for the token lexer, byte stream in, token results out
// depends on tll_pkg and tl1_token_lexer; a scoreboard class predicts every result of each transfer

module tb_tl1_token_lexer;
    import tll_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int WATCHDOG_CYCLES = 500000;
    localparam int NEST_OPENS      = 6;
    localparam logic [2:0] MODE_ADDR = {REG_START_IN_COMMENT, 2'b00};
    localparam logic [7:0] FEF_SET [7] = '{8'h09, CH_LF, 8'h0B, CH_FF, 8'h0D, CH_CAN, CH_SPACE};

    // predicts the token stream and checks the results against it
    class lex_scoreboard;
        typedef enum logic [3:0] {
            ST_IDLE, ST_SLASH, ST_BSL, ST_FEF, ST_WORD, ST_TEXT, ST_TEXT_ESC,
            ST_SUBTEXT, ST_SUBTEXT_ESC, ST_INNER, ST_INNER_ESC, ST_INNER_QUOTE,
            ST_CMT, ST_CMT_STAR, ST_CMT_SLASH, ST_CMT_NL
        } lex_state_e;

        lex_state_e               mode;
        logic [NEST_BITS_DEF-1:0] depth;
        logic [7:0]               held;
        bit                       seen;
        bit                       comment_first;
        t_out_item                pending_q[$];
        t_out_item                burst[$];
        int                       fault_count;

        function new();
            restart();
            comment_first = 1'b0;
            fault_count   = 0;
        endfunction

        function void restart();
            mode  = ST_IDLE;
            depth = '0;
            held  = 8'h00;
            seen  = 1'b0;
        endfunction

        // byte classes, everything above DEL is skipped
        static function logic [2:0] char_kind(logic [7:0] c);
            if (c[7])
                return CLS_IGN;
            if (c == CH_SPACE || c == CH_CAN || (c >= 8'h09 && c <= 8'h0D))
                return CLS_FEF;
            if (c < CH_SPACE)
                return CLS_IGN;
            // , : ; < >
            if (c == 8'h2C || c == 8'h3A || c == 8'h3B || c == 8'h3C || c == CH_GT)
                return CLS_SEP;
            if (c >= 8'h30 && c <= 8'h39)
                return CLS_NUM;
            if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                return CLS_ALF;
            return CLS_CHA;
        endfunction

        function void put(logic [2:0] kind, logic [7:0] b, bit valid, bit tok_first,
                          bit tok_done);
            t_out_item r;
            r.token_kind   = kind;
            r.value_byte   = valid ? b : 8'h00;
            r.byte_valid   = valid;
            r.token_first  = tok_first;
            r.token_done   = tok_done;
            r.last_of_item = 1'b0;
            if (burst.size() < MAX_RES)
                burst.push_back(r);
        endfunction

        // a byte seen between tokens
        function void begin_token(logic [7:0] ch);
            logic [2:0] cls;
            cls = char_kind(ch);
            if (cls == CLS_FEF) begin
                put(K_FEF, ch, 1, 1, 0);
                mode = ST_FEF;
            end else if (cls == CLS_SEP) begin
                put(K_CHAR, ch, 1, 1, 1);
                mode = ST_IDLE;
            end else if (ch == CH_QUOTE) begin
                put(K_TEXT, 8'h00, 0, 1, 0);
                mode = ST_TEXT;
            end else if (ch == CH_SLASH) begin
                mode = ST_SLASH;
            end else if (ch == CH_BSL) begin
                mode = ST_BSL;
            end else begin
                put(K_GEN, ch, 1, 1, 0);
                mode = ST_WORD;
            end
        endfunction

        function void open_comment();
            put(K_COM, 8'h00, 0, 1, 0);
            depth = NEST_BITS_DEF'(1);
            held  = 8'h00;
            mode  = ST_CMT;
        endfunction

        // star, slash and line ends are held until the next byte decides them
        function void take_comment(logic [7:0] ch, bit slash_nests);
            if (ch == CH_STAR) begin
                held = ch;
                mode = ST_CMT_STAR;
            end else if (slash_nests && ch == CH_SLASH) begin
                held = ch;
                mode = ST_CMT_SLASH;
            end else if (ch == CH_LF || ch == CH_FF) begin
                held = ch;
                mode = ST_CMT_NL;
            end else begin
                put(K_COM, ch, 1, 0, 0);
                mode = ST_CMT;
            end
        endfunction

        // end of message closes the open token, held comment bytes are lost
        function void finish_message();
            case (mode)
                ST_SLASH: put(K_CHAR, CH_SLASH, 1, 1, 1);
                ST_BSL:   put(K_CHAR, CH_BSL, 1, 1, 1);
                ST_FEF:   put(K_FEF, 8'h00, 0, 0, 1);
                ST_WORD:  put(K_GEN, 8'h00, 0, 0, 1);
                ST_TEXT, ST_TEXT_ESC, ST_SUBTEXT, ST_SUBTEXT_ESC:
                    put(K_TEXT, 8'h00, 0, 0, 1);
                ST_INNER, ST_INNER_ESC, ST_INNER_QUOTE:
                    put(K_INNER, 8'h00, 0, 0, 1);
                ST_CMT, ST_CMT_STAR, ST_CMT_SLASH, ST_CMT_NL:
                    put(K_COM, 8'h00, 0, 0, 1);
                default: ;
            endcase
            put(K_END, 8'h00, 0, 1, 1);
            restart();
        endfunction

        function void lex_byte(logic [7:0] ch);
            logic [2:0] cls;
            cls = char_kind(ch);
            case (mode)
                ST_SLASH: begin
                    if (ch == CH_STAR) begin
                        open_comment();
                    end else begin
                        put(K_CHAR, CH_SLASH, 1, 1, 1);
                        begin_token(ch);
                    end
                end
                ST_BSL: begin
                    if (ch == CH_QUOTE) begin
                        put(K_INNER, 8'h00, 0, 1, 0);
                        mode = ST_INNER;
                    end else begin
                        put(K_CHAR, CH_BSL, 1, 1, 1);
                        begin_token(ch);
                    end
                end
                ST_FEF: begin
                    if (cls == CLS_FEF) begin
                        put(K_FEF, ch, 1, 0, 0);
                    end else begin
                        put(K_FEF, 8'h00, 0, 0, 1);
                        begin_token(ch);
                    end
                end
                ST_WORD: begin
                    if (cls inside {CLS_ALF, CLS_NUM, CLS_CHA}) begin
                        put(K_GEN, ch, 1, 0, 0);
                    end else begin
                        put(K_GEN, 8'h00, 0, 0, 1);
                        begin_token(ch);
                    end
                end
                ST_TEXT: begin
                    if (ch == CH_QUOTE) begin
                        put(K_TEXT, 8'h00, 0, 0, 1);
                        mode = ST_IDLE;
                    end else if (ch == CH_BSL) begin
                        mode = ST_TEXT_ESC;
                    end else begin
                        put(K_TEXT, ch, 1, 0, 0);
                    end
                end
                ST_TEXT_ESC: begin
                    if (ch == CH_BSL) begin
                        put(K_TEXT, CH_BSL, 1, 0, 0);
                        mode = ST_TEXT;
                    end else if (ch == CH_QUOTE) begin
                        put(K_TEXT, CH_BSL, 1, 0, 0);
                        put(K_TEXT, CH_QUOTE, 1, 0, 0);
                        mode = ST_SUBTEXT;
                    end else begin
                        put(K_TEXT, CH_SPACE, 1, 0, 0);
                        mode = ST_TEXT;
                    end
                end
                // string inside text: every byte kept
                ST_SUBTEXT: begin
                    put(K_TEXT, ch, 1, 0, 0);
                    if (ch == CH_BSL)
                        mode = ST_SUBTEXT_ESC;
                end
                ST_SUBTEXT_ESC: begin
                    put(K_TEXT, ch, 1, 0, 0);
                    if (ch == CH_BSL) begin
                        mode = ST_SUBTEXT;
                    end else if (ch == CH_QUOTE) begin
                        mode = ST_TEXT;
                    end else begin
                        put(K_TEXT, ch, 1, 0, 0);
                        mode = ST_SUBTEXT;
                    end
                end
                ST_INNER: begin
                    if (ch == CH_BSL)
                        mode = ST_INNER_ESC;
                    else if (ch == CH_QUOTE)
                        mode = ST_INNER_QUOTE;
                    else
                        put(K_INNER, ch, 1, 0, 0);
                end
                ST_INNER_ESC: begin
                    if (ch == CH_BSL) begin
                        put(K_INNER, CH_BSL, 1, 0, 0);
                        mode = ST_INNER;
                    end else if (ch == CH_QUOTE) begin
                        put(K_INNER, 8'h00, 0, 0, 1);
                        mode = ST_IDLE;
                    end else begin
                        put(K_INNER, CH_SPACE, 1, 0, 0);
                        put(K_INNER, ch, 1, 0, 0);
                        mode = ST_INNER;
                    end
                end
                // doubled quote gives one quote, a lone quote eats the next byte
                ST_INNER_QUOTE: begin
                    if (ch == CH_QUOTE)
                        put(K_INNER, CH_QUOTE, 1, 0, 0);
                    mode = ST_INNER;
                end
                ST_CMT: take_comment(ch, 1'b1);
                ST_CMT_STAR: begin
                    if (ch == CH_SLASH && depth != 0)
                        depth--;
                    if (ch == CH_SLASH && depth == 0) begin
                        put(K_COM, 8'h00, 0, 0, 1);
                        mode = ST_IDLE;
                    end else begin
                        put(K_COM, held, 1, 0, 0);
                        take_comment(ch, 1'b0);
                    end
                end
                // nested opening, depth saturates at all ones
                ST_CMT_SLASH: begin
                    put(K_COM, held, 1, 0, 0);
                    put(K_COM, ch, 1, 0, 0);
                    if (ch == CH_STAR) begin
                        if (depth != '1)
                            depth++;
                        mode = ST_CMT;
                    end else if (ch != CH_SLASH) begin
                        mode = ST_CMT;
                    end
                end
                ST_CMT_NL: begin
                    if (ch == CH_GT) begin
                        put(K_COMNE, 8'h00, 0, 0, 1);
                        mode = ST_IDLE;
                    end else begin
                        put(K_COM, held, 1, 0, 0);
                        take_comment(ch, 1'b0);
                    end
                end
                default: begin_token(ch);
            endcase
        endfunction

        // accepted input transfer: queue the results it causes
        function void note_input(t_in_item it);
            burst.delete();
            if (!it.end_of_message && char_kind(it.data_byte) == CLS_IGN)
                return;
            if (!seen) begin
                seen = 1'b1;
                if (comment_first && mode == ST_IDLE)
                    open_comment();
            end
            if (it.end_of_message)
                finish_message();
            else
                lex_byte(it.data_byte);
            if (burst.size() > 0)
                burst[burst.size()-1].last_of_item = 1'b1;
            foreach (burst[i])
                pending_q.push_back(burst[i]);
        endfunction

        task report(string msg);
            fault_count++;
            if (fault_count <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // accepted result transfer against the oldest prediction
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h", got.token_kind,
                                 got.value_byte));
                return;
            end
            want = pending_q.pop_front();
            if (got.token_kind !== want.token_kind || got.value_byte !== want.value_byte ||
                got.byte_valid !== want.byte_valid || got.token_first !== want.token_first ||
                got.token_done !== want.token_done || got.last_of_item !== want.last_of_item)
                report($sformatf({"got kind=%0d byte=%02h v%0b f%0b d%0b l%0b, ",
                                  "want kind=%0d byte=%02h v%0b f%0b d%0b l%0b"},
                                 got.token_kind, got.value_byte, got.byte_valid,
                                 got.token_first, got.token_done, got.last_of_item,
                                 want.token_kind, want.value_byte, want.byte_valid,
                                 want.token_first, want.token_done, want.last_of_item));
        endtask
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    t_in_item    i_data  = '0;
    logic        full;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_item   o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    lex_scoreboard sb;
    t_in_item      msg_q[$];
    int            lexed_items = 0;
    int            sender_idle = 0;
    int            recv_stall  = 0;

    tl1_token_lexer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_data   (i_data),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side backpressure
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall);
    end

    // transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_result(o_result);
            if (push && !full)
                sb.note_input(i_data);
        end
    end

    // message building
    function automatic void add_byte(logic [7:0] b);
        msg_q.push_back({b, 1'b0});
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_end();
        msg_q.push_back({8'($urandom_range(255)), 1'b1});
    endfunction

    function automatic logic [7:0] pick_plain(logic [7:0] x0, logic [7:0] x1);
        logic [7:0] b;
        do b = 8'($urandom_range(8'h7F, 8'h20)); while (b == x0 || b == x1);
        return b;
    endfunction

    function automatic logic [7:0] skipped_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (lex_scoreboard::char_kind(b) != CLS_IGN);
        return b;
    endfunction

    // one token with random content, mostly well-formed
    function automatic void add_token();
        logic [7:0] b;
        int         lvl;
        string      seps;
        seps = ",:;<>";
        case ($urandom_range(9))
            0, 1: begin
                do b = 8'($urandom_range(8'h7F, 8'h21));
                while (!(lex_scoreboard::char_kind(b) inside {CLS_ALF, CLS_NUM, CLS_CHA}) ||
                       b inside {CH_QUOTE, CH_SLASH, CH_BSL});
                add_byte(b);
                repeat ($urandom_range(5)) begin
                    do b = 8'($urandom_range(8'h7F, 8'h21));
                    while (!(lex_scoreboard::char_kind(b) inside {CLS_ALF, CLS_NUM, CLS_CHA}));
                    add_byte(b);
                end
            end
            2: add_byte(seps[$urandom_range(4)]);
            3: repeat ($urandom_range(3, 1)) add_byte(FEF_SET[$urandom_range(6)]);
            // quoted text with escapes and a string inside
            4: begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(5)) begin
                    case ($urandom_range(3))
                        0: add_byte(pick_plain(CH_QUOTE, CH_BSL));
                        1: begin add_byte(CH_BSL); add_byte(CH_BSL); end
                        2: begin add_byte(CH_BSL); add_byte(pick_plain(CH_QUOTE, CH_BSL)); end
                        default: begin
                            add_byte(CH_BSL);
                            add_byte(CH_QUOTE);
                            repeat ($urandom_range(3)) begin
                                if ($urandom_range(2) != 0) begin
                                    add_byte(pick_plain(CH_QUOTE, CH_BSL));
                                end else begin
                                    add_byte(CH_BSL);
                                    add_byte($urandom_range(1) ? CH_BSL
                                                               : pick_plain(CH_QUOTE, CH_BSL));
                                end
                            end
                            add_byte(CH_BSL);
                            add_byte(CH_QUOTE);
                        end
                    endcase
                end
                add_byte(CH_QUOTE);
            end
            // backslash-quoted inner string
            5: begin
                add_byte(CH_BSL);
                add_byte(CH_QUOTE);
                repeat ($urandom_range(5)) begin
                    case ($urandom_range(4))
                        0: add_byte(pick_plain(CH_QUOTE, CH_BSL));
                        1: begin add_byte(CH_BSL); add_byte(CH_BSL); end
                        2: begin add_byte(CH_BSL); add_byte(pick_plain(CH_QUOTE, CH_BSL)); end
                        3: begin add_byte(CH_QUOTE); add_byte(CH_QUOTE); end
                        default: begin add_byte(CH_QUOTE); add_byte(pick_plain(CH_QUOTE, 8'h00)); end
                    endcase
                end
                add_byte(CH_BSL);
                add_byte(CH_QUOTE);
            end
            // comment, possibly nested, closed by star-slash or line end and '>'
            6, 7: begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                lvl = 1;
                repeat ($urandom_range(6)) begin
                    case ($urandom_range(5))
                        0: add_byte(pick_plain(CH_STAR, CH_SLASH));
                        1: begin add_byte(CH_STAR); add_byte(pick_plain(CH_STAR, CH_SLASH)); end
                        2: begin add_byte(CH_SLASH); add_byte(pick_plain(CH_STAR, CH_SLASH)); end
                        3: begin
                            if ($urandom_range(1))
                                add_byte(CH_SLASH);
                            add_byte(CH_SLASH);
                            add_byte(CH_STAR);
                            lvl++;
                        end
                        4: begin
                            if (lvl > 1) begin
                                add_byte(CH_STAR);
                                add_byte(CH_SLASH);
                                lvl--;
                            end else begin
                                add_byte(CH_STAR);
                                add_byte(CH_STAR);
                            end
                        end
                        default: begin
                            add_byte($urandom_range(1) ? CH_LF : CH_FF);
                            add_byte(pick_plain(CH_GT, CH_STAR));
                        end
                    endcase
                end
                if ($urandom_range(3) == 0) begin
                    add_byte($urandom_range(1) ? CH_LF : CH_FF);
                    add_byte(CH_GT);
                end else begin
                    repeat (lvl) begin
                        add_byte(CH_STAR);
                        add_byte(CH_SLASH);
                    end
                end
            end
            8: add_byte($urandom_range(1) ? CH_SLASH : CH_BSL);
            default: add_byte(8'($urandom_range(255)));
        endcase
    endfunction

    // one input transfer with random sender gaps
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < sender_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        if (it.end_of_message || lex_scoreboard::char_kind(it.data_byte) != CLS_IGN)
            lexed_items++;
    endtask

    // send the built message with the odd skipped byte mixed in
    task automatic send_message();
        t_in_item junk;
        foreach (msg_q[i]) begin
            if ($urandom_range(19) == 0) begin
                junk = {skipped_byte(), 1'b0};
                send_item(junk);
            end
            send_item(msg_q[i]);
        end
        msg_q.delete();
    endtask

    task automatic run_random(int budget);
        int start;
        start = lexed_items;
        while (lexed_items - start < budget) begin
            repeat ($urandom_range(6, 1)) add_token();
            // broken message: cut short before the end item
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1))
                    if (msg_q.size() > 0)
                        void'(msg_q.pop_back());
            add_end();
            send_message();
        end
    endtask

    // sender holds off until every predicted result has come out
    task automatic hold_until_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic drain_results();
        int n;
        n = 0;
        push <= 1'b0;
        do begin
            @(negedge i_clk);
            n++;
        end while (sb.pending_q.size() != 0 && n < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write start_in_comment, then read it back
    task automatic program_mode(bit v);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'b0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.comment_first = v;
        if (rd !== {31'b0, v})
            sb.report($sformatf("start_in_comment read back %08h after writing %0b", rd, v));
    endtask

    // run limit
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("tl1_token_lexer verification failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, separator, format effectors, lone slash and backslash,
        // text with a string inside, comment closed by line end and '>', end inside a comment
        program_mode(1'b0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_DEL);
        add_str(",\t /x\\1\"\\\"q\\\"\"");
        add_end();
        add_str("/*\n>");
        add_end();
        add_str("/*a*");
        add_end();
        send_message();
        drain_results();

        // no idling, opened-comment mode, nested comments closed level by level
        program_mode(1'b1);
        for (int i = 0; i < NEST_OPENS; i++)
            add_str("/*");
        for (int i = 0; i < NEST_OPENS + 1; i++)
            add_str("*/");
        add_str("zz");
        add_end();
        send_message();
        run_random(40);
        drain_results();

        // sender mostly idle, with a full hold-off halfway
        program_mode(1'b0);
        sender_idle = 79;
        run_random(25);
        hold_until_drained();
        run_random(25);
        drain_results();

        // receiver mostly stalled
        program_mode(1'b1);
        sender_idle = 0;
        recv_stall  = 79;
        run_random(45);
        drain_results();

        // both sides idling now and then
        program_mode(1'b0);
        sender_idle = 25;
        recv_stall  = 25;
        run_random(45);
        drain_results();

        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d predicted results never came out", sb.pending_q.size()));
        if (sb.fault_count == 0)
            $display("tl1_token_lexer verification clean");
        else
            $display("tl1_token_lexer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tll_pkg.sv
hw/rtl/tll_front.sv
hw/rtl/tll_queue.sv
hw/rtl/tll_back.sv
hw/rtl/tl1_token_lexer.sv
hw/rtl/tll_checker.sv
dv/tb_tl1_token_lexer.sv
